FILE: rtl/rtch_pkg.sv
// Shared types, constants, saturating helpers and the sequencer program of the ray/triangle unit.
`default_nettype none

package rtch_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int MAX_TRI_DEF   = 65536;
    localparam int FRAC_MIN      = 8;
    localparam int IDX_W         = 16;
    localparam int CFG_AW        = 5;

    localparam logic [63:0] S64_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] S64_MIN = 64'h8000_0000_0000_0000;

    // configuration register indexes
    localparam logic [2:0] REG_OX  = 3'd0;
    localparam logic [2:0] REG_OY  = 3'd1;
    localparam logic [2:0] REG_OZ  = 3'd2;
    localparam logic [2:0] REG_DX  = 3'd3;
    localparam logic [2:0] REG_DY  = 3'd4;
    localparam logic [2:0] REG_DZ  = 3'd5;
    localparam logic [2:0] REG_LIM = 3'd6;

    typedef enum logic [3:0] {
        OP_SUB, OP_ADD, OP_MUL, OP_SQA, OP_DIV, OP_BRLT, OP_BRZ, OP_EDGE,
        OP_BRIN, OP_KEEP, OP_BPX, OP_BPY, OP_BPZ, OP_END
    } op_t;

    typedef logic [5:0] addr_t;

    typedef struct packed {
        op_t   op;
        addr_t dst;
        addr_t a;
        addr_t b;
    } instr_t;

    // operand sources below MEM_BASE are the captured triangle and the ray registers
    localparam addr_t V1X = 6'd0,  V1Y = 6'd1,  V1Z = 6'd2;
    localparam addr_t V2X = 6'd3,  V2Y = 6'd4,  V2Z = 6'd5;
    localparam addr_t V3X = 6'd6,  V3Y = 6'd7,  V3Z = 6'd8;
    localparam addr_t OX  = 6'd9,  OY  = 6'd10, OZ  = 6'd11;
    localparam addr_t DX  = 6'd12, DY  = 6'd13, DZ  = 6'd14;
    localparam addr_t NIL = 6'd15;
    localparam addr_t MEM_BASE = 6'd16;

    // scratch memory
    localparam addr_t E0X = 6'd16, E0Y = 6'd17, E0Z = 6'd18;
    localparam addr_t E1X = 6'd19, E1Y = 6'd20, E1Z = 6'd21;
    localparam addr_t E2X = 6'd22, E2Y = 6'd23, E2Z = 6'd24;
    localparam addr_t WX  = 6'd25, WY  = 6'd26, WZ  = 6'd27;
    localparam addr_t NX  = 6'd28, NY  = 6'd29, NZ  = 6'd30;
    localparam addr_t T1  = 6'd31, T2  = 6'd32, DEN = 6'd33;
    localparam addr_t AX  = 6'd34, AY  = 6'd35, AZ  = 6'd36;
    localparam addr_t TP  = 6'd37;
    localparam addr_t PX  = 6'd38, PY  = 6'd39, PZ  = 6'd40;
    localparam addr_t QX  = 6'd41, QY  = 6'd42, QZ  = 6'd43;
    localparam addr_t CX  = 6'd44, CY  = 6'd45, CZ  = 6'd46;
    localparam addr_t GX  = 6'd47, GY  = 6'd48, GZ  = 6'd49;

    localparam int PROG_LEN = 114;
    localparam int PC_W     = $clog2(PROG_LEN);

    localparam instr_t PROG [PROG_LEN] = '{
        // edges and v3-v1
        '{OP_SUB, E0X, V2X, V1X}, '{OP_SUB, E0Y, V2Y, V1Y}, '{OP_SUB, E0Z, V2Z, V1Z},
        '{OP_SUB, E1X, V3X, V2X}, '{OP_SUB, E1Y, V3Y, V2Y}, '{OP_SUB, E1Z, V3Z, V2Z},
        '{OP_SUB, E2X, V1X, V3X}, '{OP_SUB, E2Y, V1Y, V3Y}, '{OP_SUB, E2Z, V1Z, V3Z},
        '{OP_SUB, WX,  V3X, V1X}, '{OP_SUB, WY,  V3Y, V1Y}, '{OP_SUB, WZ,  V3Z, V1Z},
        // normal
        '{OP_MUL, T1, E0Y, WZ}, '{OP_MUL, T2, E0Z, WY}, '{OP_SUB, NX, T1, T2},
        '{OP_MUL, T1, E0Z, WX}, '{OP_MUL, T2, E0X, WZ}, '{OP_SUB, NY, T1, T2},
        '{OP_MUL, T1, E0X, WY}, '{OP_MUL, T2, E0Y, WX}, '{OP_SUB, NZ, T1, T2},
        // degenerate test
        '{OP_MUL, T1, NX, NX}, '{OP_MUL, T2, NY, NY}, '{OP_ADD, T1, T1, T2},
        '{OP_MUL, T2, NZ, NZ}, '{OP_ADD, T1, T1, T2}, '{OP_BRLT, NIL, T1, NIL},
        // denominator
        '{OP_MUL, T1, DX, NX}, '{OP_MUL, T2, DY, NY}, '{OP_ADD, T1, T1, T2},
        '{OP_MUL, T2, DZ, NZ}, '{OP_ADD, DEN, T1, T2}, '{OP_BRZ, NIL, DEN, NIL},
        // numerator and plane parameter
        '{OP_SUB, AX, V1X, OX}, '{OP_SUB, AY, V1Y, OY}, '{OP_SUB, AZ, V1Z, OZ},
        '{OP_MUL, T1, AX, NX}, '{OP_MUL, T2, AY, NY}, '{OP_ADD, T1, T1, T2},
        '{OP_MUL, T2, AZ, NZ}, '{OP_ADD, T1, T1, T2}, '{OP_DIV, TP, T1, DEN},
        // point
        '{OP_MUL, T1, TP, DX}, '{OP_ADD, PX, OX, T1},
        '{OP_MUL, T1, TP, DY}, '{OP_ADD, PY, OY, T1},
        '{OP_MUL, T1, TP, DZ}, '{OP_ADD, PZ, OZ, T1},
        // edge 0
        '{OP_SUB, QX, PX, V1X}, '{OP_SUB, QY, PY, V1Y}, '{OP_SUB, QZ, PZ, V1Z},
        '{OP_MUL, T1, E0Y, QZ}, '{OP_MUL, T2, E0Z, QY}, '{OP_SUB, CX, T1, T2},
        '{OP_MUL, T1, E0Z, QX}, '{OP_MUL, T2, E0X, QZ}, '{OP_SUB, CY, T1, T2},
        '{OP_MUL, T1, E0X, QY}, '{OP_MUL, T2, E0Y, QX}, '{OP_SUB, CZ, T1, T2},
        '{OP_MUL, T1, CX, NX}, '{OP_MUL, T2, CY, NY}, '{OP_ADD, T1, T1, T2},
        '{OP_MUL, T2, CZ, NZ}, '{OP_ADD, T1, T1, T2}, '{OP_EDGE, NIL, T1, NIL},
        // edge 1
        '{OP_SUB, QX, PX, V2X}, '{OP_SUB, QY, PY, V2Y}, '{OP_SUB, QZ, PZ, V2Z},
        '{OP_MUL, T1, E1Y, QZ}, '{OP_MUL, T2, E1Z, QY}, '{OP_SUB, CX, T1, T2},
        '{OP_MUL, T1, E1Z, QX}, '{OP_MUL, T2, E1X, QZ}, '{OP_SUB, CY, T1, T2},
        '{OP_MUL, T1, E1X, QY}, '{OP_MUL, T2, E1Y, QX}, '{OP_SUB, CZ, T1, T2},
        '{OP_MUL, T1, CX, NX}, '{OP_MUL, T2, CY, NY}, '{OP_ADD, T1, T1, T2},
        '{OP_MUL, T2, CZ, NZ}, '{OP_ADD, T1, T1, T2}, '{OP_EDGE, NIL, T1, NIL},
        // edge 2
        '{OP_SUB, QX, PX, V3X}, '{OP_SUB, QY, PY, V3Y}, '{OP_SUB, QZ, PZ, V3Z},
        '{OP_MUL, T1, E2Y, QZ}, '{OP_MUL, T2, E2Z, QY}, '{OP_SUB, CX, T1, T2},
        '{OP_MUL, T1, E2Z, QX}, '{OP_MUL, T2, E2X, QZ}, '{OP_SUB, CY, T1, T2},
        '{OP_MUL, T1, E2X, QY}, '{OP_MUL, T2, E2Y, QX}, '{OP_SUB, CZ, T1, T2},
        '{OP_MUL, T1, CX, NX}, '{OP_MUL, T2, CY, NY}, '{OP_ADD, T1, T1, T2},
        '{OP_MUL, T2, CZ, NZ}, '{OP_ADD, T1, T1, T2}, '{OP_EDGE, NIL, T1, NIL},
        // inside test, distance, keep
        '{OP_BRIN, NIL, NIL, NIL},
        '{OP_SUB, GX, PX, OX}, '{OP_SUB, GY, PY, OY}, '{OP_SUB, GZ, PZ, OZ},
        '{OP_SQA, NIL, GX, GX}, '{OP_SQA, NIL, GY, GY}, '{OP_SQA, NIL, GZ, GZ},
        '{OP_KEEP, NIL, NIL, NIL},
        '{OP_BPX, NIL, PX, NIL}, '{OP_BPY, NIL, PY, NIL}, '{OP_BPZ, NIL, PZ, NIL},
        '{OP_END, NIL, NIL, NIL}
    };

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a + b;
        if (a[63] == b[63] && r[63] != a[63]) begin
            r = a[63] ? S64_MIN : S64_MAX;
        end
        return r;
    endfunction

    function automatic logic [63:0] sat_sub(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] r;
        r = a - b;
        if (a[63] != b[63] && r[63] != a[63]) begin
            r = a[63] ? S64_MIN : S64_MAX;
        end
        return r;
    endfunction

    function automatic logic [63:0] mag(input logic [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    function automatic logic [31:0] sat32(input logic [63:0] v);
        logic [31:0] r;
        if (&v[63:31] || ~|v[63:31]) begin
            r = v[31:0];
        end else begin
            r = v[63] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        return r;
    endfunction

    function automatic logic [63:0] sx32(input logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/ray_triangle_closest_hit_top.sv
// Ray/triangle closest-hit unit: APB ray registers, triangle stream in, one nearest-hit result out.
`default_nettype none

// Usage
//  - Ray origin, direction and degenerate limit are APB registers at byte addresses 4*i;
//    the user writes them only while idle (unenforced); pready is tied high, reads return them.
//  - Triangles arrive on the s_ channel, one per transfer, three vertices in s_tdata and
//    s_tlast marking the last triangle of a set. s_tready is high only while idle.
//  - Each triangle is run by a small sequencer over a 64-bit scratch memory, one shared
//    32x32 multiplier (four passes per product) and a bit-serial divider.
//    Each step is fetched and then executed; a product then runs the multiplier passes
//    and a write-back step, the plane divide the divider loop and a write-back step.
//    A triangle is taken in the idle step and ends in the finish step; a degenerate or
//    parallel one ends at its branch, one that fails the inside test before the
//    distance and keep steps.
//  - On the last triangle one result transfer is presented on the m_ channel from an
//    output register; the next set may start meanwhile. If a further result is due while
//    the previous one is still stalled, the unit waits in its finish step.
//  - Reset (aresetn low, synchronous) restores the register defaults, clears the kept hit
//    and the triangle counter and drops m_tvalid. No clearing pass is needed.
module ray_triangle_closest_hit_top #(
    parameter int FRAC_BITS     = rtch_pkg::FRAC_BITS_DEF,
    parameter int MAX_TRIANGLES = rtch_pkg::MAX_TRI_DEF
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        s_tvalid,
    output logic                             s_tready,
    // first_vertex_x/y/z, second_vertex_x/y/z, third_vertex_x/y/z, 32 bits each
    input  wire logic [287:0]                s_tdata,
    input  wire logic                        s_tlast,
    output logic                             m_tvalid,
    input  wire logic                        m_tready,
    // hit_index[15:0], hit_distance_sq[79:16], hit_x[111:80], hit_y[143:112], hit_z[175:144]
    output logic [175:0]                     m_tdata,
    // any_hit
    output logic [0:0]                       m_tuser,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rtch_pkg::CFG_AW-1:0] paddr,
    input  wire logic [31:0]                 pwdata,
    output logic [31:0]                      prdata,
    output logic                             pready
);

    localparam int DIV_W  = 64 + FRAC_BITS;           // significant dividend bits
    localparam int DCNT_W = $clog2(DIV_W);
    localparam int DPAD   = 32 - 2 * rtch_pkg::FRAC_MIN;
    localparam int DSH    = DPAD + 2 * FRAC_BITS - 32; // rescale squares to 32 frac bits
    localparam int DWW    = 128 + DPAD;
    localparam logic [24:0] MAXT = 25'(MAX_TRIANGLES);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_FETCH = 8'b0000_0010,
        S_EXEC  = 8'b0000_0100,
        S_MUL   = 8'b0000_1000,
        S_MULF  = 8'b0001_0000,
        S_DIV   = 8'b0010_0000,
        S_DIVF  = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;

    // ray registers
    logic [31:0] ox_reg, oy_reg, oz_reg, dx_reg, dy_reg, dz_reg;
    logic [15:0] lim_reg;

    // triangle capture and set state
    logic [287:0]                 tri_reg;
    logic                         last_reg;
    logic [rtch_pkg::IDX_W-1:0]   cnt_reg, pos_reg, best_pos_reg;
    logic [rtch_pkg::PC_W-1:0]    pc_reg;
    logic                         found_reg, pos_all_reg, neg_all_reg, upd_reg;
    logic [63:0]                  best_dist_reg;
    logic [31:0]                  bx_reg, by_reg, bz_reg;
    logic [127:0]                 dacc_reg;

    // sequencer and operand path
    rtch_pkg::instr_t ir_reg, fetch_ins;
    logic [63:0] mem_q [64];
    logic [63:0] rda_reg, rdb_reg, exa_reg, exb_reg, opa, opb;
    logic        sela_reg, selb_reg;
    logic        mem_we;
    logic [63:0] mem_wdata;

    // multiplier
    logic [63:0]  ma_reg, mb_reg;
    logic         mneg_reg;
    logic [1:0]   mk_reg;
    logic [127:0] macc_reg, macc_next, mr, ms, pp_w;
    logic [63:0]  pp, mul_res;

    // divider
    logic [63:0]       dd_reg, rem_reg, div_res;
    logic [DIV_W-1:0]  dvd_reg, quo_reg;
    logic [DCNT_W-1:0] dcnt_reg;
    logic              dneg_reg, d_ge;
    logic [64:0]       rtry;

    // keep logic
    logic [DWW-1:0]  dwide;
    logic [63:0]     dsq;
    logic            upd;
    logic [16:0]     cnt_inc;
    logic [rtch_pkg::IDX_W-1:0] cnt_wrap;
    logic            emit, cfg_wr;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ox_reg  <= '0;
            oy_reg  <= '0;
            oz_reg  <= '0;
            dx_reg  <= '0;
            dy_reg  <= '0;
            dz_reg  <= 32'h0001_0000;
            lim_reg <= '0;
        end else if (cfg_wr) begin
            case (paddr[4:2])
                rtch_pkg::REG_OX:  ox_reg  <= pwdata;
                rtch_pkg::REG_OY:  oy_reg  <= pwdata;
                rtch_pkg::REG_OZ:  oz_reg  <= pwdata;
                rtch_pkg::REG_DX:  dx_reg  <= pwdata;
                rtch_pkg::REG_DY:  dy_reg  <= pwdata;
                rtch_pkg::REG_DZ:  dz_reg  <= pwdata;
                rtch_pkg::REG_LIM: lim_reg <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[4:2])
            rtch_pkg::REG_OX:  prdata = ox_reg;
            rtch_pkg::REG_OY:  prdata = oy_reg;
            rtch_pkg::REG_OZ:  prdata = oz_reg;
            rtch_pkg::REG_DX:  prdata = dx_reg;
            rtch_pkg::REG_DY:  prdata = dy_reg;
            rtch_pkg::REG_DZ:  prdata = dz_reg;
            rtch_pkg::REG_LIM: prdata = {16'd0, lim_reg};
            default:           prdata = '0;
        endcase
    end

    // ---------------- operand fetch ----------------
    // Low operand codes pick the triangle or ray registers; the rest the scratch memory.
    function automatic logic [63:0] ext_val(input rtch_pkg::addr_t ad);
        logic [63:0] v;
        case (ad)
            rtch_pkg::V1X: v = rtch_pkg::sx32(tri_reg[31:0]);
            rtch_pkg::V1Y: v = rtch_pkg::sx32(tri_reg[63:32]);
            rtch_pkg::V1Z: v = rtch_pkg::sx32(tri_reg[95:64]);
            rtch_pkg::V2X: v = rtch_pkg::sx32(tri_reg[127:96]);
            rtch_pkg::V2Y: v = rtch_pkg::sx32(tri_reg[159:128]);
            rtch_pkg::V2Z: v = rtch_pkg::sx32(tri_reg[191:160]);
            rtch_pkg::V3X: v = rtch_pkg::sx32(tri_reg[223:192]);
            rtch_pkg::V3Y: v = rtch_pkg::sx32(tri_reg[255:224]);
            rtch_pkg::V3Z: v = rtch_pkg::sx32(tri_reg[287:256]);
            rtch_pkg::OX:  v = rtch_pkg::sx32(ox_reg);
            rtch_pkg::OY:  v = rtch_pkg::sx32(oy_reg);
            rtch_pkg::OZ:  v = rtch_pkg::sx32(oz_reg);
            rtch_pkg::DX:  v = rtch_pkg::sx32(dx_reg);
            rtch_pkg::DY:  v = rtch_pkg::sx32(dy_reg);
            rtch_pkg::DZ:  v = rtch_pkg::sx32(dz_reg);
            default:       v = '0;
        endcase
        return v;
    endfunction

    assign fetch_ins = rtch_pkg::PROG[pc_reg];

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem_q[ir_reg.dst] <= mem_wdata;
        end
        if (state_reg == S_FETCH) begin
            rda_reg <= mem_q[fetch_ins.a];
            rdb_reg <= mem_q[fetch_ins.b];
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == S_FETCH) begin
            ir_reg   <= fetch_ins;
            exa_reg  <= ext_val(fetch_ins.a);
            exb_reg  <= ext_val(fetch_ins.b);
            sela_reg <= fetch_ins.a < rtch_pkg::MEM_BASE;
            selb_reg <= fetch_ins.b < rtch_pkg::MEM_BASE;
        end
    end

    assign opa = sela_reg ? exa_reg : rda_reg;
    assign opb = selb_reg ? exb_reg : rdb_reg;

    // ---------------- shared multiplier ----------------
    always_comb begin
        pp        = (mk_reg[0] ? ma_reg[63:32] : ma_reg[31:0]) *
                    (mk_reg[1] ? mb_reg[63:32] : mb_reg[31:0]);
        pp_w      = {64'd0, pp} << {mk_reg[0] & mk_reg[1], mk_reg[0] ^ mk_reg[1], 5'd0};
        macc_next = macc_reg + pp_w;
        mr        = mneg_reg ? (128'd0 - macc_reg) : macc_reg;
        ms        = $signed(mr) >>> FRAC_BITS;   // floor
        if (&ms[127:63] || ~|ms[127:63]) begin
            mul_res = ms[63:0];
        end else begin
            mul_res = ms[127] ? rtch_pkg::S64_MIN : rtch_pkg::S64_MAX;
        end
    end

    // ---------------- bit-serial divider ----------------
    always_comb begin
        rtry = {rem_reg, dvd_reg[DIV_W-1]};
        d_ge = rtry >= {1'b0, dd_reg};
        if (dneg_reg) begin
            if (|quo_reg[DIV_W-1:64] || quo_reg[63:0] > rtch_pkg::S64_MIN) begin
                div_res = rtch_pkg::S64_MIN;
            end else begin
                div_res = 64'd0 - quo_reg[63:0];
            end
        end else if (|quo_reg[DIV_W-1:63]) begin
            div_res = rtch_pkg::S64_MAX;
        end else begin
            div_res = quo_reg[63:0];
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            S_EXEC: begin
                ma_reg   <= rtch_pkg::mag(opa);
                mb_reg   <= rtch_pkg::mag(opb);
                mneg_reg <= opa[63] ^ opb[63];
                mk_reg   <= '0;
                macc_reg <= '0;
                dd_reg   <= rtch_pkg::mag(opb);
                dneg_reg <= opa[63] ^ opb[63];
                dvd_reg  <= DIV_W'(rtch_pkg::mag(opa)) << FRAC_BITS;
                rem_reg  <= '0;
                quo_reg  <= '0;
                dcnt_reg <= '0;
            end
            S_MUL: begin
                macc_reg <= macc_next;
                mk_reg   <= mk_reg + 2'd1;
            end
            S_DIV: begin
                rem_reg  <= d_ge ? 64'(rtry - {1'b0, dd_reg}) : rtry[63:0];
                quo_reg  <= {quo_reg[DIV_W-2:0], d_ge};
                dvd_reg  <= dvd_reg << 1;
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            default: ;
        endcase
    end

    // ---------------- distance and keep ----------------
    always_comb begin
        dwide = {dacc_reg, DPAD'(0)} >> DSH;
        dsq   = |dwide[DWW-1:64] ? '1 : dwide[63:0];
        upd   = !found_reg || dsq < best_dist_reg;
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = '0;
        case (state_reg)
            S_EXEC: begin
                case (ir_reg.op)
                    rtch_pkg::OP_SUB: begin
                        mem_we    = 1'b1;
                        mem_wdata = rtch_pkg::sat_sub(opa, opb);
                    end
                    rtch_pkg::OP_ADD: begin
                        mem_we    = 1'b1;
                        mem_wdata = rtch_pkg::sat_add(opa, opb);
                    end
                    default: ;
                endcase
            end
            S_MULF: begin
                mem_we    = ir_reg.op == rtch_pkg::OP_MUL;
                mem_wdata = mul_res;
            end
            S_DIVF: begin
                mem_we    = 1'b1;
                mem_wdata = div_res;
            end
            default: ;
        endcase
    end

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:  if (s_tvalid) state_next = S_FETCH;
            S_FETCH: state_next = S_EXEC;
            S_EXEC: begin
                case (ir_reg.op)
                    rtch_pkg::OP_MUL, rtch_pkg::OP_SQA: state_next = S_MUL;
                    rtch_pkg::OP_DIV:  state_next = S_DIV;
                    rtch_pkg::OP_BRLT: begin
                        state_next = ($signed(opa) < $signed({48'd0, lim_reg})) ? S_DONE
                                                                                  : S_FETCH;
                    end
                    rtch_pkg::OP_BRZ:  state_next = (opa == '0) ? S_DONE : S_FETCH;
                    rtch_pkg::OP_BRIN: begin
                        state_next = (pos_all_reg || neg_all_reg) ? S_FETCH : S_DONE;
                    end
                    rtch_pkg::OP_END:  state_next = S_DONE;
                    default:           state_next = S_FETCH;
                endcase
            end
            S_MUL:   if (mk_reg == 2'd3) state_next = S_MULF;
            S_MULF:  state_next = S_FETCH;
            S_DIV:   if (dcnt_reg == DCNT_W'(DIV_W - 1)) state_next = S_DIVF;
            S_DIVF:  state_next = S_FETCH;
            S_DONE:  if (!last_reg || emit) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    assign s_tready = state_reg == S_IDLE;
    assign emit     = (state_reg == S_DONE) && last_reg && (!m_tvalid || m_tready);
    assign cnt_inc  = {1'b0, cnt_reg} + 17'd1;
    assign cnt_wrap = (cnt_inc[16] || {8'd0, cnt_inc} >= MAXT) ? '0 : cnt_inc[15:0];

    // triangle capture and distance accumulator (payload)
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            tri_reg  <= s_tdata;
            last_reg <= s_tlast;
            dacc_reg <= '0;
        end else if (state_reg == S_MULF && ir_reg.op == rtch_pkg::OP_SQA) begin
            dacc_reg <= dacc_reg + macc_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            pc_reg        <= '0;
            cnt_reg       <= '0;
            pos_reg       <= '0;
            found_reg     <= 1'b0;
            best_dist_reg <= '1;
            best_pos_reg  <= '0;
            bx_reg        <= '0;
            by_reg        <= '0;
            bz_reg        <= '0;
            pos_all_reg   <= 1'b1;
            neg_all_reg   <= 1'b1;
            upd_reg       <= 1'b0;
            m_tvalid      <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (m_tvalid && m_tready) begin
                m_tvalid <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_tvalid) begin
                        pos_reg     <= cnt_reg;
                        cnt_reg     <= cnt_wrap;
                        pc_reg      <= '0;
                        pos_all_reg <= 1'b1;
                        neg_all_reg <= 1'b1;
                    end
                end
                S_EXEC: begin
                    pc_reg <= pc_reg + 1'b1;
                    case (ir_reg.op)
                        rtch_pkg::OP_EDGE: begin
                            if (opa[63]) pos_all_reg <= 1'b0;
                            if (!opa[63] && |opa) neg_all_reg <= 1'b0;
                        end
                        rtch_pkg::OP_KEEP: begin
                            upd_reg <= upd;
                            if (upd) begin
                                found_reg     <= 1'b1;
                                best_dist_reg <= dsq;
                                best_pos_reg  <= pos_reg;
                            end
                        end
                        rtch_pkg::OP_BPX: if (upd_reg) bx_reg <= rtch_pkg::sat32(opa);
                        rtch_pkg::OP_BPY: if (upd_reg) by_reg <= rtch_pkg::sat32(opa);
                        rtch_pkg::OP_BPZ: if (upd_reg) bz_reg <= rtch_pkg::sat32(opa);
                        default: ;
                    endcase
                end
                S_DONE: begin
                    if (emit) begin
                        // result leaves through the output register; set starts afresh
                        m_tvalid      <= 1'b1;
                        found_reg     <= 1'b0;
                        best_dist_reg <= '1;
                        best_pos_reg  <= '0;
                        bx_reg        <= '0;
                        by_reg        <= '0;
                        bz_reg        <= '0;
                        cnt_reg       <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tuser <= found_reg;
            m_tdata <= {bz_reg, by_reg, bx_reg,
                        found_reg ? best_dist_reg : 64'd0, best_pos_reg};
        end
    end

    // ---------------- assertions ----------------
    a_nohit_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        !found_reg |-> (best_dist_reg == '1 && best_pos_reg == '0))
        else $error("kept hit state dirty with no hit found");

    a_emit_on_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(last_reg))
        else $error("result presented for a triangle not marked last");

    a_mul_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_MULF |-> $past(state_reg) == S_MUL && $past(mk_reg) == 2'd3)
        else $error("multiplier finished early");

    a_div_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_DIV |-> dcnt_reg < DCNT_W'(DIV_W))
        else $error("divider ran past its last step");

    a_idle_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == S_FETCH && pc_reg == '0)
        else $error("accepted triangle did not start the program");

endmodule

`default_nettype wire
